FILE: src/ordered_frame_list_top_defines.svh
// Assertion macros shared by the checker files.
`ifndef ORDERED_FRAME_LIST_TOP_DEFINES_SVH
`define ORDERED_FRAME_LIST_TOP_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define OFL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered frame list check failed");

// Next-cycle implication, disabled in reset.
`define OFL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered frame list check failed");

`endif

FILE: src/ofl_pkg.sv
// Shared constants, types and codes of the ordered frame list.
package ofl_pkg;
    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 12;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_count;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_POP    = 2'd2,
        KIND_TEST   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISSING = 2'd1,
        STATUS_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_APPLY
    } t_state;

    typedef struct packed {
        logic load_req;
        logic load_match;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_stat;
endpackage

FILE: src/ofl_chan_if.sv
// Request and response channel interfaces of the ordered frame list.
interface ofl_req_if
    import ofl_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    t_value      value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface ofl_rsp_if
    import ofl_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    t_value      data;
    t_count      occupancy;

    modport source (output valid, output status, output data, output occupancy, input ready);
    modport sink   (input valid, input status, input data, input occupancy, output ready);
endinterface

FILE: src/ordered_frame_list_top.sv
// Ordered frame list: bounded FIFO/LRU order keeper with delete by value.
//
// Request channel i_req carries kind (append, remove, pop, presence test)
// and a 12-bit frame number. Response channel o_rsp returns one beat per
// request: status (ok/found, not found or empty, full), the frame number
// taken out by remove or pop (zero otherwise), and occupancy afterwards.
// Up to 16 entries; duplicates kept, remove takes the one nearest the head.
// The request is captured, the compare across all entries is registered,
// then the update with gap closing writes the response register; a new
// request is taken only after the previous one has reached the update.
// A new request is taken while the previous response still waits.
// If o_rsp is stalled, the update of the following request waits until
// the response register frees up; i_req.ready stays low meanwhile.
// Reset empties the list and drops any pending response; store contents
// are left as they are and never affect a response before being written.
module ordered_frame_list_top
    import ofl_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ofl_req_if.sink         i_req,
    ofl_rsp_if.source       o_rsp
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    ofl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ofl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (i_req.kind),
        .i_value     (i_req.value),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_data      (o_rsp.data),
        .o_occupancy (o_rsp.occupancy)
    );
endmodule

FILE: src/ofl_ctrl.sv
// Controller state machine sequencing accept, compare and update.
module ofl_ctrl
    import ofl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.load_match = 1'b1;
                n_state          = S_APPLY;
            end
            S_APPLY: begin
                if (!i_stat.out_busy) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: src/ofl_dp.sv
// Datapath: entry store, parallel compare, gap closing and response register.
module ofl_dp
    import ofl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [1:0]  i_kind,
    input  t_value      i_value,
    input  logic        i_rsp_ready,
    output logic        o_rsp_valid,
    output logic [1:0]  o_status,
    output t_value      o_data,
    output t_count      o_occupancy
);
    t_kind              r_kind;
    t_value             r_value;
    logic [DEPTH-1:0]   r_match;
    t_value             r_store [DEPTH];
    t_value             n_store [DEPTH];
    t_count             r_count;
    t_count             n_count;
    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    t_value             r_data;
    t_value             n_data;

    logic               found;
    t_idx               hit_pos;
    t_idx               sh_pos;
    t_idx               wr_idx;
    logic               do_write;
    logic               do_shift;

    assign wr_idx = r_count[IDX_W-1:0];

    // first match nearest the head
    always_comb begin
        found   = 1'b0;
        hit_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                found   = 1'b1;
                hit_pos = t_idx'(i);
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = STATUS_OK;
        do_write = 1'b0;
        do_shift = 1'b0;
        sh_pos   = hit_pos;
        unique case (r_kind)
            KIND_APPEND: begin
                if (r_count == t_count'(DEPTH)) begin
                    n_status = STATUS_FULL;
                end else begin
                    do_write = 1'b1;
                    n_count  = r_count + t_count'(1);
                end
            end
            KIND_REMOVE: begin
                if (found) begin
                    do_shift = 1'b1;
                    n_count  = r_count - t_count'(1);
                end else begin
                    n_status = STATUS_MISSING;
                end
            end
            KIND_POP: begin
                sh_pos = '0;
                if (r_count == '0) begin
                    n_status = STATUS_MISSING;
                end else begin
                    do_shift = 1'b1;
                    n_count  = r_count - t_count'(1);
                end
            end
            KIND_TEST: begin
                if (!found) begin
                    n_status = STATUS_MISSING;
                end
            end
        endcase
        n_data = do_shift ? r_store[sh_pos] : '0;
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_store[i] = r_store[i];
            if (do_write && (t_idx'(i) == wr_idx)) begin
                n_store[i] = r_value;
            end
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (do_shift && (t_idx'(i) >= sh_pos)) begin
                n_store[i] = r_store[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_kind  <= t_kind'(i_kind);
            r_value <= i_value;
        end
        if (i_cmd.load_match) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (r_store[i] == r_value) && (t_count'(i) < r_count);
            end
        end
        if (i_cmd.apply) begin
            r_store  <= n_store;
            r_status <= n_status;
            r_data   <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_data          = r_data;
    assign o_occupancy     = r_count;
endmodule

FILE: src/ofl_chk.sv
// Port-level checker for the ordered frame list, bound to the top level.
`include "ordered_frame_list_top_defines.svh"

module ofl_chk
    import ofl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [1:0]  i_status,
    input t_value      i_data,
    input t_count      i_occupancy
);
    `OFL_ASSERT_NOW(a_occ_bound, i_clk, i_rst_n, i_rsp_valid, i_occupancy <= t_count'(DEPTH))
    `OFL_ASSERT_NOW(a_full_occ, i_clk, i_rst_n, i_rsp_valid && (i_status == STATUS_FULL), i_occupancy == t_count'(DEPTH))
    `OFL_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, i_rsp_valid && (i_status != STATUS_OK), i_data == '0)
    `OFL_ASSERT_NEXT(a_one_at_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)
    `OFL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_data) && $stable(i_occupancy))
endmodule

bind ordered_frame_list_top ofl_chk u_ofl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_data      (o_rsp.data),
    .i_occupancy (o_rsp.occupancy)
);

FILE: verif/tb_ordered_frame_list_top.sv
// Self-checking testbench of the ordered frame list: directed and random requests.
`timescale 1ns / 100ps

module tb_ordered_frame_list_top;
    import ofl_pkg::*;

    localparam int RANDOM_REQS    = 1426;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PRINT_LIMIT    = 100;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        t_kind       kind;
        t_value      value;
        int unsigned gap;
        bit          drain;
    } t_frame_req;

    typedef struct packed {
        t_status status;
        t_value  data;
        t_count  occupancy;
    } t_frame_rsp;

    bit   clk;
    logic rst_n;

    ofl_req_if req_if ();
    ofl_rsp_if rsp_if ();

    ordered_frame_list_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_frame_req  req_backlog[$];
    t_frame_rsp  predicted_outcomes[$];
    t_value      frame_order[$];

    int unsigned req_issued;
    int unsigned req_taken;
    int unsigned rsp_hold;
    int unsigned rsp_mode;
    int unsigned rsp_seen;
    int unsigned quiet_cycles;
    int unsigned mismatch_count;
    int unsigned peak_occupancy;
    int unsigned kind_seen[4];
    int unsigned status_seen[3];

    always #4 clk = ~clk;

    // mode 0: no idling, 1: full range, 2: mostly back to back
    function automatic int unsigned idle_draw(int unsigned mode);
        case (mode)
            0: return 0;
            1: return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    function automatic t_frame_rsp apply_frame_request(t_kind kind, t_value value);
        t_frame_rsp outcome;
        int         hit;
        outcome.status = STATUS_OK;
        outcome.data   = '0;
        hit = -1;
        foreach (frame_order[i]) begin
            if (hit < 0 && frame_order[i] == value) hit = i;
        end
        case (kind)
            KIND_APPEND: begin
                if (frame_order.size() >= DEPTH) outcome.status = STATUS_FULL;
                else frame_order.push_back(value);
            end
            KIND_REMOVE: begin
                if (hit < 0) begin
                    outcome.status = STATUS_MISSING;
                end else begin
                    outcome.data = frame_order[hit];
                    frame_order.delete(hit);
                end
            end
            KIND_POP: begin
                if (frame_order.size() == 0) outcome.status = STATUS_MISSING;
                else outcome.data = frame_order.pop_front();
            end
            default: begin
                if (hit < 0) outcome.status = STATUS_MISSING;
            end
        endcase
        outcome.occupancy = t_count'(frame_order.size());
        if (frame_order.size() > peak_occupancy) peak_occupancy = frame_order.size();
        return outcome;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_req(input t_kind kind, input t_value value, input int unsigned gap,
                             input bit drain);
        t_frame_req item;
        item.kind  = kind;
        item.value = value;
        item.gap   = gap;
        item.drain = drain;
        req_backlog.push_back(item);
    endtask

    // request driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req_if.valid || req_taken == req_issued) begin
                if (req_backlog.size() != 0 && req_backlog[0].gap != 0) begin
                    req_backlog[0].gap = req_backlog[0].gap - 1;
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() != 0 &&
                             !(req_backlog[0].drain && predicted_outcomes.size() != 0)) begin
                    req_if.valid <= 1'b1;
                    req_if.kind  <= req_backlog[0].kind;
                    req_if.value <= req_backlog[0].value;
                    req_issued++;
                    req_backlog.delete(0);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response backpressure
    always @(negedge clk) begin
        if (rsp_hold != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold--;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk) begin
        t_frame_rsp want;
        if (rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_seen++;
                if (rsp_seen % 64 == 0) rsp_mode = $urandom_range(0, 2);
                rsp_hold = idle_draw(rsp_mode);
                if (predicted_outcomes.size() == 0) begin
                    report_mismatch("response beat with no request outstanding");
                end else begin
                    want = predicted_outcomes.pop_front();
                    if (want.status <= STATUS_FULL) status_seen[want.status]++;
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp_if.status, want.status));
                    if (rsp_if.data !== want.data)
                        report_mismatch($sformatf("data got 0x%03h want 0x%03h",
                                                  rsp_if.data, want.data));
                    if (rsp_if.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy got %0d want %0d",
                                                  rsp_if.occupancy, want.occupancy));
                end
            end
            if (req_if.valid && req_if.ready) begin
                kind_seen[req_if.kind]++;
                predicted_outcomes.push_back(apply_frame_request(t_kind'(req_if.kind),
                                                                 req_if.value));
                req_taken++;
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_value      pool[8];
        int unsigned fill_bias;
        int unsigned gap_mode;
        t_kind       kind;
        t_value      value;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.kind  = KIND_APPEND;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        rsp_mode     = 1;

        // empty list corner cases
        queue_req(KIND_POP, 12'hFFF, idle_draw(1), 1'b0);
        queue_req(KIND_REMOVE, 12'h000, idle_draw(1), 1'b0);
        queue_req(KIND_TEST, 12'hFFF, idle_draw(1), 1'b0);
        // fill to capacity with extremes and duplicates
        queue_req(KIND_APPEND, 12'h000, idle_draw(1), 1'b0);
        queue_req(KIND_APPEND, 12'hFFF, idle_draw(1), 1'b0);
        queue_req(KIND_APPEND, 12'h005, idle_draw(1), 1'b0);
        queue_req(KIND_APPEND, 12'hAAA, idle_draw(1), 1'b0);
        queue_req(KIND_APPEND, 12'h555, idle_draw(1), 1'b0);
        queue_req(KIND_APPEND, 12'h005, idle_draw(1), 1'b0);
        for (int i = 0; i < DEPTH - 6; i++)
            queue_req(KIND_APPEND, t_value'($urandom_range(0, 4095)), idle_draw(2), 1'b0);
        queue_req(KIND_APPEND, 12'h123, idle_draw(1), 1'b0);
        queue_req(KIND_TEST, 12'hFFF, idle_draw(1), 1'b0);
        queue_req(KIND_REMOVE, 12'h005, idle_draw(1), 1'b0);
        queue_req(KIND_REMOVE, 12'h123, idle_draw(1), 1'b1);
        queue_req(KIND_POP, 12'h000, idle_draw(1), 1'b0);

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 120 == 0) begin
                fill_bias = $urandom_range(15, 85);
                gap_mode  = $urandom_range(0, 2);
                foreach (pool[i]) pool[i] = t_value'($urandom_range(0, 4095));
                if ($urandom_range(0, 1)) pool[0] = '0;
                if ($urandom_range(0, 1)) pool[1] = '1;
            end
            if ($urandom_range(0, 99) < fill_bias) kind = KIND_APPEND;
            else kind = t_kind'($urandom_range(1, 3));
            if ($urandom_range(0, 9) < 8) value = pool[$urandom_range(0, 7)];
            else value = t_value'($urandom_range(0, 4095));
            queue_req(kind, value, idle_draw(gap_mode), n % 300 == 0);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || req_taken != req_issued) @(posedge clk);
        while (predicted_outcomes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d appends, %0d removes, %0d pops, %0d tests",
                 req_taken, kind_seen[KIND_APPEND], kind_seen[KIND_REMOVE],
                 kind_seen[KIND_POP], kind_seen[KIND_TEST]);
        $display("Outcomes: %0d ok, %0d missing or empty, %0d full; peak occupancy %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_MISSING],
                 status_seen[STATUS_FULL], peak_occupancy);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
